/* hw/rtl/ps2fr_pkg.sv */
// ps2fr_pkg: shared types, constants and helpers of the ps2 frame receiver
// no dependencies; used by every module of the block
`timescale 1ns / 1ps

package ps2fr_pkg;

   // receive byte fifo geometry
   localparam int FIFO_SLOTS = 64;
   localparam int SLOT_W     = (FIFO_SLOTS > 1) ? $clog2(FIFO_SLOTS) : 1;

   // frame and timing constants
   localparam logic [3:0]  FRAME_BITS = 4'd11;
   localparam logic [15:0] GAP_RESET  = 16'd250;

   // request operation codes
   localparam logic OP_EDGE = 1'b0;
   localparam logic OP_READ = 1'b1;

   // command codes between front and back
   localparam logic [1:0] CMD_NONE = 2'd0;
   localparam logic [1:0] CMD_PUSH = 2'd1;
   localparam logic [1:0] CMD_READ = 2'd2;

   // configuration register index and port width
   localparam int   CSR_ADDR_W    = 3;
   localparam logic REG_FRAME_GAP = 1'b0;

   typedef struct packed {
      logic        operation;
      logic        data_bit;
      logic [31:0] now_ms;
   } req_type;

   typedef struct packed {
      logic       read_valid;
      logic [7:0] read_byte;
      logic       byte_stored;
      logic       byte_dropped;
   } rsp_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] data;
   } cmd_type;

   // ring advance of a fifo slot
   function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
      logic [SLOT_W-1:0] n;
      if (s == SLOT_W'(FIFO_SLOTS - 1)) begin
         n = '0;
      end else begin
         n = s + SLOT_W'(1);
      end
      return n;
   endfunction

endpackage

/* hw/rtl/ps2fr_front.sv */
// ps2fr_front: frame assembly from ps2 clock edges, classifies each request
// depends on ps2fr_pkg
`timescale 1ns / 1ps

module ps2fr_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  ps2fr_pkg::req_type  req,
   input  logic [15:0]         frame_gap_ms,
   output ps2fr_pkg::cmd_type  cmd
);

   logic [3:0]  bit_index_ff, bit_index_in;
   logic [7:0]  shift_byte_ff, shift_byte_in;
   logic [31:0] last_edge_ff, last_edge_in;

   logic [31:0] gap;
   logic        restart;
   logic [3:0]  bi_cur;
   logic [7:0]  sb_cur;
   logic [7:0]  sb_new;
   logic [3:0]  bi_new;
   logic [2:0]  bit_pos;

   // frame state update and command classification
   always_comb begin
      gap     = req.now_ms - last_edge_ff;
      restart = gap > {16'd0, frame_gap_ms};
      bi_cur  = restart ? 4'd0 : bit_index_ff;
      sb_cur  = restart ? 8'd0 : shift_byte_ff;
      bit_pos = 3'(bi_cur - 4'd1);
      sb_new  = sb_cur;
      if (bi_cur >= 4'd1 && bi_cur <= 4'd8) begin
         sb_new = sb_cur | (8'(req.data_bit) << bit_pos);
      end
      bi_new = bi_cur + 4'd1;

      bit_index_in  = bit_index_ff;
      shift_byte_in = shift_byte_ff;
      last_edge_in  = last_edge_ff;
      cmd.kind      = ps2fr_pkg::CMD_READ;
      cmd.data      = 8'd0;
      if (req.operation == ps2fr_pkg::OP_EDGE) begin
         last_edge_in = req.now_ms;
         cmd.kind     = ps2fr_pkg::CMD_NONE;
         if (bi_new >= ps2fr_pkg::FRAME_BITS) begin
            cmd.kind      = ps2fr_pkg::CMD_PUSH;
            cmd.data      = sb_new;
            bit_index_in  = 4'd0;
            shift_byte_in = 8'd0;
         end else begin
            bit_index_in  = bi_new;
            shift_byte_in = sb_new;
         end
      end
   end

   // frame state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         bit_index_ff  <= 4'd0;
         shift_byte_ff <= 8'd0;
         last_edge_ff  <= 32'd0;
      end else if (accept) begin
         bit_index_ff  <= bit_index_in;
         shift_byte_ff <= shift_byte_in;
         last_edge_ff  <= last_edge_in;
      end
   end

endmodule

/* hw/rtl/ps2fr_cmd_queue.sv */
// ps2fr_cmd_queue: two-entry command queue between front and back
// depends on ps2fr_pkg
`timescale 1ns / 1ps

module ps2fr_cmd_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  ps2fr_pkg::cmd_type  push_cmd,
   output logic                not_full,
   input  logic                pop,
   output logic                not_empty,
   output ps2fr_pkg::cmd_type  head
);

   ps2fr_pkg::cmd_type entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign not_full  = (count_ff != 2'd2);
   assign not_empty = (count_ff != 2'd0);
   assign head      = entry_ff[rd_ptr_ff];

   // pointer and occupancy update
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

/* hw/rtl/ps2fr_back.sv */
// ps2fr_back: receive byte ring fifo and response register
// depends on ps2fr_pkg
`timescale 1ns / 1ps

module ps2fr_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                cmd_valid,
   input  ps2fr_pkg::cmd_type  cmd,
   output logic                cmd_pop,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output ps2fr_pkg::rsp_type  rsp_data
);

   localparam int SW = ps2fr_pkg::SLOT_W;

   logic [7:0]    byte_store [ps2fr_pkg::FIFO_SLOTS];
   logic [SW-1:0] write_slot_ff, write_slot_in;
   logic [SW-1:0] read_slot_ff, read_slot_in;
   logic          rsp_valid_ff;
   logic          read_valid_ff, read_valid_in;
   logic          stored_ff, stored_in;
   logic          dropped_ff, dropped_in;
   logic [7:0]    rd_data_ff;

   logic          mem_we;
   logic          mem_re;
   logic [SW-1:0] wr_next;
   logic [SW-1:0] rd_next;

   assign cmd_pop = cmd_valid && (!rsp_valid_ff || rsp_ready);

   // fifo command execution
   always_comb begin
      wr_next       = ps2fr_pkg::next_slot(write_slot_ff);
      rd_next       = ps2fr_pkg::next_slot(read_slot_ff);
      write_slot_in = write_slot_ff;
      read_slot_in  = read_slot_ff;
      read_valid_in = 1'b0;
      stored_in     = 1'b0;
      dropped_in    = 1'b0;
      mem_we        = 1'b0;
      mem_re        = 1'b0;
      case (cmd.kind)
         ps2fr_pkg::CMD_PUSH: begin
            if (wr_next != read_slot_ff) begin
               mem_we        = cmd_pop;
               write_slot_in = wr_next;
               stored_in     = 1'b1;
            end else begin
               dropped_in = 1'b1;
            end
         end
         ps2fr_pkg::CMD_READ: begin
            if (read_slot_ff != write_slot_ff) begin
               mem_re        = cmd_pop;
               read_slot_in  = rd_next;
               read_valid_in = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   // pointers and response control
   always_ff @(posedge clock) begin
      if (reset) begin
         write_slot_ff <= '0;
         read_slot_ff  <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (cmd_pop) begin
            write_slot_ff <= write_slot_in;
            read_slot_ff  <= read_slot_in;
            rsp_valid_ff  <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // response flags
   always_ff @(posedge clock) begin
      if (cmd_pop) begin
         read_valid_ff <= read_valid_in;
         stored_ff     <= stored_in;
         dropped_ff    <= dropped_in;
      end
   end

   // byte store, one write and one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         byte_store[wr_next] <= cmd.data;
      end
      if (mem_re) begin
         rd_data_ff <= byte_store[rd_next];
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_data.read_valid   = read_valid_ff;
   assign rsp_data.read_byte    = read_valid_ff ? rd_data_ff : 8'd0;
   assign rsp_data.byte_stored  = stored_ff;
   assign rsp_data.byte_dropped = dropped_ff;

endmodule

/* hw/rtl/ps2_frame_receiver_fifo.sv */
// ps2_frame_receiver_fifo: top level, csr register and front/queue/back wiring
// depends on ps2fr_pkg, ps2fr_front, ps2fr_cmd_queue, ps2fr_back
//
//   channel   direction  handshake               payload
//   req_      in         req_valid / req_ready   req_data (ps2fr_pkg::req_type)
//   rsp_      out        rsp_valid / rsp_ready   rsp_data (ps2fr_pkg::rsp_type)
//   csr_      in/out     apb psel/penable/pready frame_gap_ms at address 0
//
// one request per cycle sustained while rsp_ready is held; the front writes the
// command queue when a request is accepted, and the fifo step then loads the response
// register from the queue head. reset is synchronous and clears frame state, queue and
// fifo pointers; the byte store has no clearing pass. a stalled response holds the
// back, the two-entry queue keeps accepting until it fills, then req_ready drops.
`timescale 1ns / 1ps

module ps2_frame_receiver_fifo (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  ps2fr_pkg::req_type                 req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output ps2fr_pkg::rsp_type                 rsp_data,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [ps2fr_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [31:0]                        csr_pwdata,
   output logic [31:0]                        csr_prdata,
   output logic                               csr_pready
);

   logic [15:0]        frame_gap_ff;
   logic               req_accept;
   logic               q_not_full;
   logic               q_not_empty;
   logic               q_pop;
   ps2fr_pkg::cmd_type front_cmd;
   ps2fr_pkg::cmd_type q_head;
   logic               csr_reg_idx;

   // configuration register access
   assign csr_pready  = 1'b1;
   assign csr_reg_idx = csr_paddr[2];
   assign csr_prdata  = (csr_reg_idx == ps2fr_pkg::REG_FRAME_GAP) ?
                        {16'd0, frame_gap_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_gap_ff <= ps2fr_pkg::GAP_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
                   csr_reg_idx == ps2fr_pkg::REG_FRAME_GAP) begin
         frame_gap_ff <= csr_pwdata[15:0];
      end
   end

   // request handshake
   assign req_ready  = q_not_full;
   assign req_accept = req_valid && q_not_full;

   ps2fr_front u_front (
      .clock        (clock),
      .reset        (reset),
      .accept       (req_accept),
      .req          (req_data),
      .frame_gap_ms (frame_gap_ff),
      .cmd          (front_cmd)
   );

   ps2fr_cmd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_accept),
      .push_cmd  (front_cmd),
      .not_full  (q_not_full),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .head      (q_head)
   );

   ps2fr_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (q_not_empty),
      .cmd       (q_head),
      .cmd_pop   (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
